### rtl/core/dwsc_pkg.sv
// Shared types, codes and defaults for the delayed word store controller.
package dwsc_pkg;

  // Default sizes.
  localparam int unsigned DefDepth      = 65536;
  localparam int unsigned DefDelayTicks = 4;

  // Field widths.
  localparam int unsigned WordW   = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned CountW  = 17;
  localparam int unsigned TimerW  = 8;

  localparam logic [CountW-1:0] WordCountReset = 17'h10000;

  // Request codes carried by each input word.
  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_ACK   = 2'd3
  } req_t;

  // Operation waiting for its countdown.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // Status register codes.
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_READ_OK   = 3'd1,
    ST_READ_ERR  = 3'd2,
    ST_WRITE_OK  = 3'd3,
    ST_WRITE_ERR = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WORD_COUNT = 2'd0,
    CFG_READ_IE    = 2'd1,
    CFG_WRITE_IE   = 2'd2
  } cfg_idx_t;

  // Controller sequencing.
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_RDWAIT = 1'b1
  } ctrl_state_t;

  // Configuration seen by the controller.
  typedef struct packed {
    logic [CountW-1:0] word_count;
    logic              read_ie;
    logic              write_ie;
  } cfg_t;

  // Access to the word store; at most one of rd_en and wr_en is set.
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] wdata;
  } mem_req_t;

endpackage

### rtl/core/dwsc_ram.sv
// Single-port word store with a registered read.
module dwsc_ram import dwsc_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic             clk,
  input  mem_req_t         mem_req,
  output logic [WordW-1:0] rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rd_data_r;

  // Write, or registered read.
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.addr[AW-1:0]] <= mem_req.wdata;
    end
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/dwsc_ctrl.sv
// Request sequencer: countdown, pending operation, status and result register.
module dwsc_ctrl import dwsc_pkg::*; #(
  parameter int unsigned DEPTH       = DefDepth,
  parameter int unsigned DELAY_TICKS = DefDelayTicks
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_req,
  input  logic [WordW-1:0] in_addr_lo,
  input  logic [WordW-1:0] in_addr_hi,
  input  logic [WordW-1:0] in_wval,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [WordW-1:0] out_rval,
  output logic             out_irq,
  output logic             out_busy,
  output mem_req_t         mem_req,
  input  logic [WordW-1:0] mem_rdata
);

  localparam logic [AddrW:0]    DepthW = (AddrW+1)'(DEPTH);
  localparam logic [TimerW-1:0] Delay  = TimerW'(DELAY_TICKS);

  ctrl_state_t       st_r, st_nxt;
  logic [TimerW-1:0] cnt_r, cnt_nxt;
  op_t               op_r, op_nxt;
  logic [AddrW-1:0]  addr_r, addr_nxt;
  logic [WordW-1:0]  val_r, val_nxt;
  status_t           status_r, status_nxt;
  logic [WordW-1:0]  data_r, data_nxt;

  // Word held while its read completion waits for the store.
  req_t              it_req_r;
  logic [WordW-1:0]  it_lo_r, it_hi_r, it_wv_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [WordW-1:0]  out_rval_r;
  logic              out_irq_r, out_busy_r;

  logic              in_fire, cnt_zero, addr_ok, need_rd, commit, do_wr, irq;
  req_t              req;
  logic [WordW-1:0]  lo, hi, wv;

  assign in_ready = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Select the live word or the one held over the read wait.
  assign req = (st_r == S_RDWAIT) ? it_req_r : req_t'(in_req);
  assign lo  = (st_r == S_RDWAIT) ? it_lo_r  : in_addr_lo;
  assign hi  = (st_r == S_RDWAIT) ? it_hi_r  : in_addr_hi;
  assign wv  = (st_r == S_RDWAIT) ? it_wv_r  : in_wval;

  // Bounds check of the pending address against word count and depth.
  assign cnt_zero = (cnt_r == '0);
  assign addr_ok  = ({1'b0, addr_r} < {{(AddrW+1-CountW){1'b0}}, cfg.word_count}) &&
                    ({1'b0, addr_r} < DepthW);
  assign need_rd  = cnt_zero && (op_r == OP_READ) && addr_ok;
  assign commit   = (st_r == S_RDWAIT) || (in_fire && !need_rd);

  // One tick: completion, then request, then countdown.
  always_comb begin
    cnt_nxt    = cnt_r;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    do_wr      = 1'b0;
    irq        = 1'b0;
    if (cnt_zero) begin
      case (op_r)
        OP_READ: begin
          if (addr_ok) begin
            data_nxt   = mem_rdata;
            status_nxt = ST_READ_OK;
          end else begin
            status_nxt = ST_READ_ERR;
          end
          irq = cfg.read_ie;
        end
        OP_WRITE: begin
          if (addr_ok) begin
            do_wr      = 1'b1;
            status_nxt = ST_WRITE_OK;
          end else begin
            status_nxt = ST_WRITE_ERR;
          end
          irq = cfg.write_ie;
        end
        default: ;
      endcase
      op_nxt = OP_NONE;
      case (req)
        REQ_READ, REQ_WRITE: begin
          if (status_nxt == ST_IDLE) begin
            op_nxt   = (req == REQ_READ) ? OP_READ : OP_WRITE;
            addr_nxt = {hi, lo};
            if (req == REQ_WRITE) begin
              val_nxt = wv;
            end
            cnt_nxt = Delay;
          end
        end
        REQ_ACK: status_nxt = ST_IDLE;
        default: ;
      endcase
    end
    if (cnt_nxt != '0) begin
      cnt_nxt = cnt_nxt - TimerW'(1);
    end
  end

  // Sequencing: a completing read waits in S_RDWAIT for the store.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:   if (in_fire && need_rd) st_nxt = S_RDWAIT;
      S_RDWAIT: st_nxt = S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  // Store access.
  always_comb begin
    mem_req.wr_en = commit && do_wr;
    mem_req.rd_en = (st_r == S_IDLE) && in_fire && need_rd;
    mem_req.addr  = addr_r;
    mem_req.wdata = val_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      op_r        <= OP_NONE;
      addr_r      <= '0;
      val_r       <= '0;
      status_r    <= ST_IDLE;
      data_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (commit) begin
        cnt_r    <= cnt_nxt;
        op_r     <= op_nxt;
        addr_r   <= addr_nxt;
        val_r    <= val_nxt;
        status_r <= status_nxt;
        data_r   <= data_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Held word and result payload.
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      it_req_r <= req_t'(in_req);
      it_lo_r  <= in_addr_lo;
      it_hi_r  <= in_addr_hi;
      it_wv_r  <= in_wval;
    end
    if (commit) begin
      out_status_r <= status_nxt;
      out_rval_r   <= data_nxt;
      out_irq_r    <= irq;
      out_busy_r   <= (cnt_nxt != '0);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_rval   = out_rval_r;
  assign out_irq    = out_irq_r;
  assign out_busy   = out_busy_r;

endmodule

### rtl/core/delayed_word_store_controller.sv
// Top level of the delayed word store controller: ports, configuration, store.
// Each input word is one tick that carries a request (none, read, write or
// acknowledge) and the address and value registers; each tick returns one
// result word with status, data register, interrupt pulse and busy flag. A
// read or write taken while idle completes max(DELAY_TICKS, 1) ticks later.
// A tick that completes a read at a valid address also passes through a wait
// state, because the word store has a single port with a registered read.
// The store comes up undefined and needs no clearing pass; reading a word
// never written gives an undefined value.
module delayed_word_store_controller import dwsc_pkg::*; #(
  parameter int unsigned DEPTH       = DefDepth,
  parameter int unsigned DELAY_TICKS = DefDelayTicks
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input words.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,  // address_low, address_high, write_value
  input  logic [1:0]        in_tuser,  // req_type
  // Result words.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata, // status, read_value, interrupt, busy_res, pad
  // Configuration writes.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CountW-1:0] cfg_data
);

  cfg_t             cfg_r;
  mem_req_t         mem_req;
  logic [WordW-1:0] mem_rdata;
  logic [2:0]       st;
  logic [WordW-1:0] rval;
  logic             irq, busy;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.word_count <= WordCountReset;
      cfg_r.read_ie    <= 1'b0;
      cfg_r.write_ie   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WORD_COUNT: cfg_r.word_count <= cfg_data;
        CFG_READ_IE:    cfg_r.read_ie    <= cfg_data[0];
        CFG_WRITE_IE:   cfg_r.write_ie   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dwsc_ctrl #(
    .DEPTH       (DEPTH),
    .DELAY_TICKS (DELAY_TICKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_req     (in_tuser),
    .in_addr_lo (in_tdata[15:0]),
    .in_addr_hi (in_tdata[31:16]),
    .in_wval    (in_tdata[47:32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (st),
    .out_rval   (rval),
    .out_irq    (irq),
    .out_busy   (busy),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  dwsc_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (mem_rdata)
  );

  assign out_tdata = {3'b000, busy, irq, rval, st};

  // The single store port never reads and writes in the same cycle.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("word store read and write collide");

  // A new word is taken only when the result register is free or draining.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!out_tvalid || out_tready))
    else $error("input taken while result register is blocked");

  // A store read holds off the input for the wait cycle, then presents a result.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.rd_en |=> !in_tready ##1 out_tvalid)
    else $error("read completion did not produce a result");

  // A completion never starts a new countdown, so an interrupt never comes with busy.
  a_irq_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && irq) |-> !busy)
    else $error("interrupt while countdown still running");

endmodule

### dv/tb_delayed_word_store_controller.sv
// Self-checking testbench for the delayed word store controller: directed table, then random ticks.
`timescale 1ns / 1ps

module tb_delayed_word_store_controller;
  import dwsc_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomTicks = 1100;
  localparam int unsigned Phases      = 10;

  // One input word as the block sees it.
  typedef struct packed {
    req_t        req;
    logic [15:0] addr_lo;
    logic [15:0] addr_hi;
    logic [15:0] value;
  } tick_t;

  // One result word, unpacked into its fields.
  typedef struct packed {
    status_t     status;
    logic [15:0] data;
    logic        irq;
    logic        busy;
  } outcome_t;

  // One row of the directed table: a register write or a tick with an optional typed result.
  typedef struct packed {
    logic              is_cfg;
    cfg_idx_t          cfg_idx;
    logic [CountW-1:0] cfg_val;
    tick_t             tick;
    logic              typed;
    outcome_t          want;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [47:0]       in_tdata;   // address_low, address_high, write_value
  logic [1:0]        in_tuser;   // req_type
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;  // status, read_value, interrupt, busy_res, pad
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [CountW-1:0] cfg_data;

  // Typed result that travels alongside the word being driven.
  logic     typed_now;
  outcome_t typed_want;

  // Predicted controller state and configuration.
  logic [TimerW-1:0] m_countdown;
  op_t               m_op;
  logic [AddrW-1:0]  m_addr;
  logic [WordW-1:0]  m_value;
  status_t           m_status;
  logic [WordW-1:0]  m_data;
  logic [WordW-1:0]  m_store [DefDepth];
  bit                m_written [DefDepth];
  int unsigned       written_addrs [$];
  logic [CountW-1:0] m_word_count;
  logic              m_read_ie;
  logic              m_write_ie;

  outcome_t    awaited [$];
  row_t        script [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          steady;

  delayed_word_store_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit addr_in_range(logic [AddrW-1:0] a);
    return (a < AddrW'(m_word_count)) && (a < AddrW'(DefDepth));
  endfunction

  // Advance the predicted state by one tick: completion first, then the request, then the timer.
  function automatic outcome_t tick_outcome(tick_t t);
    outcome_t o;
    o = '0;
    if (m_countdown == '0) begin
      if (m_op == OP_READ) begin
        if (addr_in_range(m_addr)) begin
          m_data   = m_store[m_addr];
          m_status = ST_READ_OK;
        end else begin
          m_status = ST_READ_ERR;
        end
        o.irq = m_read_ie;
      end else if (m_op == OP_WRITE) begin
        if (addr_in_range(m_addr)) begin
          m_store[m_addr] = m_value;
          if (!m_written[m_addr]) begin
            m_written[m_addr] = 1'b1;
            written_addrs.push_back(m_addr);
          end
          m_status = ST_WRITE_OK;
        end else begin
          m_status = ST_WRITE_ERR;
        end
        o.irq = m_write_ie;
      end
      m_op = OP_NONE;
      // A new read or write starts only if the status is still idle after the completion.
      if (t.req == REQ_READ || t.req == REQ_WRITE) begin
        if (m_status == ST_IDLE) begin
          m_op   = (t.req == REQ_READ) ? OP_READ : OP_WRITE;
          m_addr = {t.addr_hi, t.addr_lo};
          if (t.req == REQ_WRITE) m_value = t.value;
          m_countdown = TimerW'(DefDelayTicks);
        end
      end else if (t.req == REQ_ACK) begin
        m_status = ST_IDLE;
      end
    end
    if (m_countdown != '0) m_countdown = m_countdown - TimerW'(1);
    o.status = m_status;
    o.data   = m_data;
    o.busy   = (m_countdown != '0);
    return o;
  endfunction

  // A read that would start at a valid word never written is moved to a written or invalid address.
  function automatic tick_t keep_reads_defined(tick_t t);
    logic [AddrW-1:0] a;
    a = {t.addr_hi, t.addr_lo};
    if (t.req == REQ_READ && m_countdown == '0 && m_op == OP_NONE && m_status == ST_IDLE &&
        addr_in_range(a) && !m_written[a]) begin
      if (written_addrs.size() != 0)
        a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      else
        a = '1;
      {t.addr_hi, t.addr_lo} = a;
    end
    return t;
  endfunction

  // Addresses cluster in a small region and around the word count boundary.
  function automatic logic [AddrW-1:0] pick_address(req_t req);
    int unsigned span;
    int unsigned r;
    span = (m_word_count < DefDepth) ? m_word_count : DefDepth;
    r = $urandom_range(0, 99);
    if (req == REQ_READ && r < 40 && written_addrs.size() != 0)
      return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    if (r < 55) return $urandom_range(0, 63);
    if (r < 65) return $urandom_range(0, 16'hFFFF);
    if (r < 75) return span - 1;
    if (r < 90) return span + $urandom_range(0, 3);
    return $urandom;
  endfunction

  // Mostly well-formed request, wait, acknowledge sequences, with noise while busy.
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (m_countdown != '0 || m_op != OP_NONE)
      t.req = (r < 50) ? REQ_NONE : req_t'($urandom_range(0, 3));
    else if (m_status != ST_IDLE)
      t.req = (r < 70) ? REQ_ACK : req_t'($urandom_range(0, 3));
    else if (r < 45)
      t.req = REQ_WRITE;
    else if (r < 85)
      t.req = REQ_READ;
    else if (r < 93)
      t.req = REQ_NONE;
    else
      t.req = REQ_ACK;
    {t.addr_hi, t.addr_lo} = pick_address(t.req);
    t.value = $urandom;
    return keep_reads_defined(t);
  endfunction

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void add_tick(req_t req, logic [15:0] lo, logic [15:0] hi,
                                   logic [15:0] val);
    row_t r;
    r = '0;
    r.tick = '{req, lo, hi, val};
    script.push_back(r);
  endfunction

  function automatic void add_typed(req_t req, logic [15:0] lo, logic [15:0] hi,
                                    logic [15:0] val, status_t st, logic [15:0] data,
                                    logic irq, logic busy);
    row_t r;
    r = '0;
    r.tick  = '{req, lo, hi, val};
    r.typed = 1'b1;
    r.want  = '{st, data, irq, busy};
    script.push_back(r);
  endfunction

  function automatic void add_reg(cfg_idx_t idx, logic [CountW-1:0] val);
    row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    script.push_back(r);
  endfunction

  // Drive one word after a random gap and hold it until the block takes it.
  task automatic send_tick(tick_t t, logic typed, outcome_t want);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= t.req;
    in_tdata   <= {t.value, t.addr_hi, t.addr_lo};
    typed_now  <= typed;
    typed_want <= want;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Write a register once the block is quiet: no countdown running and no result outstanding.
  task automatic write_reg(cfg_idx_t idx, logic [CountW-1:0] val);
    while (m_countdown != '0 || m_op != OP_NONE) send_tick('0, 1'b0, '0);
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WORD_COUNT: m_word_count = val;
      CFG_READ_IE:    m_read_ie    = val[0];
      CFG_WRITE_IE:   m_write_ie   = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result sink: ready in runs of random length broken by random stalls.
  initial begin : result_sink
    int unsigned len;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      out_tready <= 1'b1;
      len = $urandom_range(1, 12);
      repeat (len) @(negedge clk);
      len = idle_gap();
      if (len != 0) begin
        out_tready <= 1'b0;
        repeat (len) @(negedge clk);
      end
    end
  end

  // Predict on every accepted input word and check every accepted result word.
  always @(posedge clk) begin : scoreboard
    tick_t    seen;
    outcome_t got;
    outcome_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen.req     = req_t'(in_tuser);
        seen.addr_lo = in_tdata[15:0];
        seen.addr_hi = in_tdata[31:16];
        seen.value   = in_tdata[47:32];
        want = tick_outcome(seen);
        awaited.push_back(typed_now ? typed_want : want);
      end
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tdata[2:0]);
        got.data   = out_tdata[18:3];
        got.irq    = out_tdata[19];
        got.busy   = out_tdata[20];
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            mismatches++;
          end
          if (got.data !== want.data) begin
            $display("%0t: read_value expected %h got %h", $time, want.data, got.data);
            mismatches++;
          end
          if (got.irq !== want.irq) begin
            $display("%0t: interrupt expected %b got %b", $time, want.irq, got.irq);
            mismatches++;
          end
          if (got.busy !== want.busy) begin
            $display("%0t: busy_res expected %b got %b", $time, want.busy, got.busy);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no handshake on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    tick_t             t;
    int unsigned       sent;
    logic [CountW-1:0] counts [Phases];
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = REQ_NONE;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_WORD_COUNT;
    cfg_data     = '0;
    typed_now    = 1'b0;
    typed_want   = '0;
    steady       = 1'b0;
    mismatches   = 0;
    m_countdown  = '0;
    m_op         = OP_NONE;
    m_addr       = '0;
    m_value      = '0;
    m_status     = ST_IDLE;
    m_data       = '0;
    m_word_count = WordCountReset;
    m_read_ie    = 1'b0;
    m_write_ie   = 1'b0;

    // Out of reset the block is idle, and an acknowledge changes nothing.
    add_typed(REQ_NONE, 16'h0, 16'h0, 16'h0, ST_IDLE, 16'h0, 1'b0, 1'b0);
    add_typed(REQ_ACK, 16'hFFFF, 16'hFFFF, 16'hFFFF, ST_IDLE, 16'h0, 1'b0, 1'b0);
    // Write the top word; a read and an acknowledge under the countdown are ignored.
    add_typed(REQ_WRITE, 16'hFFFF, 16'h0, 16'hFFFF, ST_IDLE, 16'h0, 1'b0, 1'b1);
    add_tick(REQ_READ, 16'h0, 16'h0, 16'h0);
    add_tick(REQ_NONE, 16'h0, 16'h0, 16'h0);
    add_tick(REQ_ACK, 16'h0, 16'h0, 16'h0);
    // The completion leaves the status not idle, so a write in the same tick is dropped.
    add_typed(REQ_WRITE, 16'h1, 16'h0, 16'hAAAA, ST_WRITE_OK, 16'h0, 1'b0, 1'b0);
    add_typed(REQ_READ, 16'hFFFF, 16'h0, 16'h0, ST_WRITE_OK, 16'h0, 1'b0, 1'b0);
    add_typed(REQ_ACK, 16'h0, 16'h0, 16'h0, ST_IDLE, 16'h0, 1'b0, 1'b0);
    // Read the top word back.
    add_tick(REQ_READ, 16'hFFFF, 16'h0, 16'h0);
    repeat (3) add_tick(REQ_NONE, 16'h0, 16'h0, 16'h0);
    add_typed(REQ_NONE, 16'h0, 16'h0, 16'h0, ST_READ_OK, 16'hFFFF, 1'b0, 1'b0);
    add_typed(REQ_ACK, 16'h0, 16'h0, 16'h0, ST_IDLE, 16'hFFFF, 1'b0, 1'b0);
    // The highest address fails; an acknowledge in the completing tick still clears it.
    add_tick(REQ_WRITE, 16'hFFFF, 16'hFFFF, 16'h0);
    repeat (3) add_tick(REQ_NONE, 16'h0, 16'h0, 16'h0);
    add_typed(REQ_ACK, 16'h0, 16'h0, 16'h0, ST_IDLE, 16'hFFFF, 1'b0, 1'b0);
    // A word count above the depth acts as the depth; an error still raises the interrupt.
    add_reg(CFG_WORD_COUNT, 17'h1FFFF);
    add_reg(CFG_READ_IE, 17'd1);
    add_reg(CFG_WRITE_IE, 17'd1);
    add_tick(REQ_READ, 16'h0, 16'h1, 16'h5555);
    repeat (3) add_tick(REQ_NONE, 16'h0, 16'h0, 16'h0);
    add_typed(REQ_READ, 16'h0, 16'h0, 16'h0, ST_READ_ERR, 16'hFFFF, 1'b1, 1'b0);
    add_typed(REQ_ACK, 16'h0, 16'h0, 16'h0, ST_IDLE, 16'hFFFF, 1'b0, 1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg)
        write_reg(script[i].cfg_idx, script[i].cfg_val);
      else
        send_tick(script[i].tick, script[i].typed, script[i].want);
    end

    // Random phases, each with its own word count and interrupt enables.
    counts = '{17'h10000, 17'd0, 17'd64, 17'h1FFFF, 17'd1,
               17'd16, 17'hFFFF, 17'd40, 17'd0, 17'h10000};
    counts[8] = CountW'($urandom_range(0, 17'h1FFFF));
    for (int p = 0; p < Phases; p++) begin
      write_reg(CFG_WORD_COUNT, counts[p]);
      write_reg(CFG_READ_IE, CountW'(p[0]));
      write_reg(CFG_WRITE_IE, CountW'(p[1]));
      steady = (p == 3 || p == 7);
      sent = 0;
      while (sent < RandomTicks / Phases) begin
        t = random_tick();
        send_tick(t, 1'b0, '0);
        sent++;
      end
    end

    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
rtl/core/dwsc_pkg.sv
rtl/core/dwsc_ram.sv
rtl/core/dwsc_ctrl.sv
rtl/core/delayed_word_store_controller.sv
dv/tb_delayed_word_store_controller.sv
